@@ hdl/ses_pkg.sv @@
// Shared types and constants of the sparse eligibility trace store.
package ses_pkg;

    typedef enum logic [2:0] {
        OP_SET    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_DECAY  = 3'd2,
        OP_UPDATE = 3'd3,
        OP_WRITE  = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    localparam logic [1:0] CFG_LR  = 2'd0;
    localparam logic [1:0] CFG_TC  = 2'd1;
    localparam logic [1:0] CFG_MIN = 2'd2;

    localparam logic [15:0] TRACE_ONE     = 16'd32768;
    localparam logic [15:0] LR_RESET      = 16'd4096;
    localparam logic [10:0] TC_RESET      = 11'd416;
    localparam logic [15:0] MIN_RESET     = 16'd328;
    // 52429 / 2^19 approximates 1/10, exact for all 17-bit numerators
    localparam logic [15:0] TENTH_RECIP   = 16'd52429;
    localparam int          TENTH_SHIFT   = 19;
    localparam int          MAG_W         = 47;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_MOD,
        ST_OPRD,
        ST_OPCHK,
        ST_CUT0,
        ST_CUT1,
        ST_CUT_CHK,
        ST_W_LIST,
        ST_W_ENT,
        ST_W_EVAL,
        ST_W_DEC,
        ST_W_NEXT,
        ST_DROP_A,
        ST_DROP_B,
        ST_DROP_C,
        ST_U_MUL,
        ST_U_ABS,
        ST_U_DIVW,
        ST_U_WALK,
        ST_U_ENT,
        ST_U_M1,
        ST_U_M2,
        ST_U_WR,
        ST_FIN_RD,
        ST_FIN_Q
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hdl/ses_ifs.sv @@
// Handshake channels of the sparse eligibility trace store.
interface ses_item_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [11:0]        feature_index;
    logic [15:0]        decay_factor;
    logic signed [31:0] td_error;
    logic signed [31:0] weight_value;
    modport source (output valid, op, feature_index, decay_factor, td_error, weight_value,
                    input ready);
    modport sink (input valid, op, feature_index, decay_factor, td_error, weight_value,
                  output ready);
endinterface

interface ses_res_if #(parameter int CW = 9);
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_out;
    logic [15:0]        trace_out;
    logic [CW-1:0]      active_count;
    logic [15:0]        min_trace_out;
    modport source (output valid, weight_out, trace_out, active_count, min_trace_out,
                    input ready);
    modport sink (input valid, weight_out, trace_out, active_count, min_trace_out,
                  output ready);
endinterface

interface ses_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/ses_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
module ses_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

@@ hdl/ses_div.sv @@
// Restoring divider, one quotient bit per cycle.
module ses_div
    import ses_pkg::*;
#(
    parameter int NW = 47,
    parameter int DW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo,
    output t_div_stat     o_stat
);
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   sh;
    logic          ge;
    logic [DW:0]   diff;

    assign sh   = {r_rem, r_num[NW-1]};
    assign ge   = sh >= {1'b0, r_den};
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_num <= {r_num[NW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_num;
    assign o_stat = '{busy: r_busy, done: r_done};
endmodule

@@ hdl/sparse_eligibility_trace_store.sv @@
// Sparse eligibility trace store: sequencer over entry and active-list RAMs.
// Decay walks every active entry and may drop some; update runs one division, then walks
// every active entry. A set on a full list raises the cut-off and runs one cull walk per
// raise until a slot is free.
// One item at a time; a new item is accepted once its result is presented.
// Reset: a clearing pass over all TABLE_DEPTH entries zeroes the entry RAM, no item accepted.
module sparse_eligibility_trace_store
    import ses_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_ACTIVE  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ses_item_if.sink    i_item,
    ses_res_if.source   o_res,
    ses_cfg_if.sink     i_cfg
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(MAX_ACTIVE);
    localparam int CW = $clog2(MAX_ACTIVE + 1);
    localparam int XW = (AW > 12) ? AW : 12;
    localparam int EW = 48 + SW;
    localparam logic [XW:0]   DEPTH_C   = (XW + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_ACTIVE);

    // entry word: {weight, trace, list slot}
    t_state             r_state, n_state, r_ret, n_ret;
    logic               r_cull, n_cull;
    logic [2:0]         r_op, n_op;
    logic [XW-1:0]      r_red, n_red;
    logic [15:0]        r_rate, n_rate;
    logic signed [31:0] r_delta, n_delta;
    logic signed [31:0] r_wv, n_wv;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [15:0]        r_min, n_min;
    logic [15:0]        r_lr, n_lr;
    logic [10:0]        r_tc, n_tc;
    logic [CW-1:0]      r_s, n_s;
    logic [SW-1:0]      r_slot, n_slot;
    logic [AW-1:0]      r_e, n_e;
    logic [EW-1:0]      r_ent, n_ent;
    logic [31:0]        r_prod, n_prod;
    logic [32:0]        r_q, n_q;
    logic signed [48:0] r_p, n_p;
    logic               r_neg, n_neg;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic [39:0]        r_pp, n_pp;
    logic [38:0]        r_ph, n_ph;
    logic [AW-1:0]      r_clr, n_clr;
    logic               r_ov, n_ov;
    logic signed [31:0] r_wo, n_wo;
    logic [15:0]        r_to, n_to;
    logic [CW-1:0]      r_co, n_co;
    logic [15:0]        r_mo, n_mo;

    logic               ent_we, ent_re, lst_we, lst_re, div_go;
    logic [AW-1:0]      ent_waddr, ent_raddr, lst_wdata;
    logic [SW-1:0]      lst_waddr, lst_raddr;
    logic [EW-1:0]      ent_wdata, ent_q;
    logic [AW-1:0]      lst_q;
    logic [MAG_W-1:0]   quo;
    t_div_stat          div_stat;
    logic [10:0]        tc_eff;

    logic [AW-1:0]      idx;
    logic signed [31:0] q_w, e_w;
    logic [15:0]        q_t, e_t;
    logic [SW-1:0]      q_p, e_p;
    logic [CW-1:0]      s_m1, cnt_m1;
    logic [32:0]        dec_sum;
    logic [17:0]        dec_raw;
    logic [16:0]        dec_t;
    logic [16:0]        min_sum;
    logic [15:0]        step;
    logic [63:0]        full;
    logic [33:0]        mag_inc;
    logic signed [34:0] wsum;
    logic signed [31:0] wsat;

    assign idx    = r_red[AW-1:0];
    assign q_w    = ent_q[EW-1 -: 32];
    assign q_t    = ent_q[SW+15 -: 16];
    assign q_p    = ent_q[SW-1:0];
    assign e_w    = r_ent[EW-1 -: 32];
    assign e_t    = r_ent[SW+15 -: 16];
    assign e_p    = r_ent[SW-1:0];
    assign s_m1   = r_s - 1'b1;
    assign cnt_m1 = r_cnt - 1'b1;
    assign tc_eff = (r_tc == '0) ? 11'd1 : r_tc;

    // decay: round to nearest, cap at 1.0
    assign dec_sum = {1'b0, r_prod} + 33'd16384;
    assign dec_raw = dec_sum[32:15];
    assign dec_t   = (dec_raw > 18'(TRACE_ONE)) ? 17'(TRACE_ONE) : dec_raw[16:0];

    // cut-off growth, step of at least one
    assign step    = (r_q[32:TENTH_SHIFT] == '0) ? 16'd1 : 16'(r_q[32:TENTH_SHIFT]);
    assign min_sum = {1'b0, r_min} + {1'b0, step};

    // weight step: join partial products, round, add with saturation
    assign full    = {1'b0, r_ph, 24'd0} + {24'd0, r_pp} + (64'd1 << 29);
    assign mag_inc = full[63:30];
    assign wsum    = r_neg ? (35'(e_w) - $signed({1'b0, mag_inc}))
                           : (35'(e_w) + $signed({1'b0, mag_inc}));
    always_comb begin
        if (wsum > 35'sd2147483647) begin
            wsat = 32'sh7FFFFFFF;
        end else if (wsum < -35'sd2147483648) begin
            wsat = 32'sh80000000;
        end else begin
            wsat = wsum[31:0];
        end
    end

    ses_ram #(.W(EW), .D(TABLE_DEPTH)) u_ent (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_q)
    );

    ses_ram #(.W(AW), .D(MAX_ACTIVE)) u_lst (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (lst_wdata),
        .i_re    (lst_re),
        .i_raddr (lst_raddr),
        .o_rdata (lst_q)
    );

    ses_div #(.NW(MAG_W), .DW(11)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_num   (r_mag),
        .i_den   (tc_eff),
        .o_quo   (quo),
        .o_stat  (div_stat)
    );

    assign i_item.ready        = (r_state == ST_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_res.valid         = r_ov;
    assign o_res.weight_out    = r_wo;
    assign o_res.trace_out     = r_to;
    assign o_res.active_count  = r_co;
    assign o_res.min_trace_out = r_mo;

    always_comb begin
        n_state = r_state;  n_ret  = r_ret;   n_cull = r_cull;  n_op   = r_op;
        n_red   = r_red;    n_rate = r_rate;  n_delta = r_delta; n_wv  = r_wv;
        n_cnt   = r_cnt;    n_min  = r_min;   n_lr   = r_lr;    n_tc   = r_tc;
        n_s     = r_s;      n_slot = r_slot;  n_e    = r_e;     n_ent  = r_ent;
        n_prod  = r_prod;   n_q    = r_q;     n_p    = r_p;     n_neg  = r_neg;
        n_mag   = r_mag;    n_pp   = r_pp;    n_ph   = r_ph;    n_clr  = r_clr;
        n_ov    = r_ov;     n_wo   = r_wo;    n_to   = r_to;    n_co   = r_co;
        n_mo    = r_mo;
        ent_we = 1'b0;  ent_waddr = r_e;  ent_wdata = r_ent;
        ent_re = 1'b0;  ent_raddr = idx;
        lst_we = 1'b0;  lst_waddr = r_slot; lst_wdata = r_e;
        lst_re = 1'b0;  lst_raddr = s_m1[SW-1:0];
        div_go = 1'b0;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        // config beats are to arrive only while idle, which the block does not enforce; min_trace loads at once
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_LR:  n_lr  = i_cfg.data;
                CFG_TC:  n_tc  = i_cfg.data[10:0];
                CFG_MIN: n_min = i_cfg.data;
                default: ;
            endcase
        end

        case (r_state)
            ST_CLR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr;
                ent_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.op;
                    n_red   = XW'(i_item.feature_index);
                    n_rate  = i_item.decay_factor;
                    n_delta = i_item.td_error;
                    n_wv    = i_item.weight_value;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                // index folded into the table, one subtraction a cycle
                if ({1'b0, r_red} >= DEPTH_C) begin
                    n_red = r_red - DEPTH_C[XW-1:0];
                end else begin
                    n_state = ST_OPRD;
                end
            end
            ST_OPRD: begin
                ent_re    = 1'b1;
                ent_raddr = idx;
                n_state   = ST_OPCHK;
            end
            ST_OPCHK: begin
                n_state = ST_FIN_RD;
                case (r_op)
                    OP_SET: begin
                        if (q_t != '0) begin
                            ent_we    = 1'b1;
                            ent_waddr = idx;
                            ent_wdata = {q_w, TRACE_ONE, q_p};
                        end else if (r_cnt >= FULL_CNT) begin
                            n_state = ST_CUT0;
                        end else begin
                            ent_we    = 1'b1;
                            ent_waddr = idx;
                            ent_wdata = {q_w, TRACE_ONE, r_cnt[SW-1:0]};
                            lst_we    = 1'b1;
                            lst_waddr = r_cnt[SW-1:0];
                            lst_wdata = idx;
                            n_cnt     = r_cnt + 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        if (q_t != '0) begin
                            n_slot  = q_p;
                            n_e     = idx;
                            n_ent   = ent_q;
                            n_ret   = ST_FIN_RD;
                            n_state = ST_DROP_A;
                        end
                    end
                    OP_DECAY: begin
                        n_s     = r_cnt;
                        n_cull  = 1'b0;
                        n_state = ST_W_LIST;
                    end
                    OP_UPDATE: begin
                        // r_s doubles as the divider start mark, so it must not hold it yet
                        n_s     = '0;
                        n_state = ST_U_MUL;
                    end
                    OP_WRITE: begin
                        ent_we    = 1'b1;
                        ent_waddr = idx;
                        ent_wdata = {r_wv, q_t, q_p};
                    end
                    default: ;
                endcase
            end
            ST_CUT0: begin
                n_q     = 33'({1'b0, r_min} + 17'd5) * 33'(TENTH_RECIP);
                n_state = ST_CUT1;
            end
            ST_CUT1: begin
                n_min   = min_sum[16] ? 16'hFFFF : min_sum[15:0];
                n_s     = r_cnt;
                n_cull  = 1'b1;
                n_state = ST_W_LIST;
            end
            ST_CUT_CHK: begin
                // raise again until a slot is free, then retry the set
                n_state = (r_cnt >= FULL_CNT) ? ST_CUT0 : ST_OPRD;
            end
            // walk of the list from the last slot down, shared by decay and cull
            ST_W_LIST: begin
                if (r_s == '0) begin
                    n_state = r_cull ? ST_CUT_CHK : ST_FIN_RD;
                end else begin
                    lst_re    = 1'b1;
                    lst_raddr = s_m1[SW-1:0];
                    n_state   = ST_W_ENT;
                end
            end
            ST_W_ENT: begin
                n_e       = lst_q;
                ent_re    = 1'b1;
                ent_raddr = lst_q;
                n_state   = ST_W_EVAL;
            end
            ST_W_EVAL: begin
                n_ent  = ent_q;
                n_slot = s_m1[SW-1:0];
                n_ret  = ST_W_NEXT;
                if (!r_cull) begin
                    n_prod  = 32'(q_t) * 32'(r_rate);
                    n_state = ST_W_DEC;
                end else if (q_t < r_min) begin
                    n_state = ST_DROP_A;
                end else begin
                    n_state = ST_W_NEXT;
                end
            end
            ST_W_DEC: begin
                if (dec_t == '0 || dec_t < {1'b0, r_min}) begin
                    n_state = ST_DROP_A;
                end else begin
                    ent_we    = 1'b1;
                    ent_waddr = r_e;
                    ent_wdata = {e_w, dec_t[15:0], e_p};
                    n_state   = ST_W_NEXT;
                end
            end
            ST_W_NEXT: begin
                n_s     = s_m1;
                n_state = ST_W_LIST;
            end
            // drop: zero the trace, move the last slot into the hole
            ST_DROP_A: begin
                ent_we    = 1'b1;
                ent_waddr = r_e;
                ent_wdata = {e_w, 16'd0, e_p};
                n_cnt     = cnt_m1;
                if (r_slot == cnt_m1[SW-1:0]) begin
                    n_state = r_ret;
                end else begin
                    lst_re    = 1'b1;
                    lst_raddr = cnt_m1[SW-1:0];
                    n_state   = ST_DROP_B;
                end
            end
            ST_DROP_B: begin
                lst_we    = 1'b1;
                lst_waddr = r_slot;
                lst_wdata = lst_q;
                n_e       = lst_q;
                ent_re    = 1'b1;
                ent_raddr = lst_q;
                n_state   = ST_DROP_C;
            end
            ST_DROP_C: begin
                ent_we    = 1'b1;
                ent_waddr = r_e;
                ent_wdata = {q_w, q_t, r_slot};
                n_state   = r_ret;
            end
            ST_U_MUL: begin
                n_p     = 49'(r_delta) * $signed({33'd0, r_lr});
                n_state = ST_U_ABS;
            end
            ST_U_ABS: begin
                n_neg   = r_p[48];
                n_mag   = r_p[48] ? MAG_W'(-r_p) : MAG_W'(r_p);
                n_state = ST_U_DIVW;
            end
            ST_U_DIVW: begin
                if (!div_stat.busy && !div_stat.done && r_s != FULL_CNT) begin
                    div_go = 1'b1;
                    n_s    = FULL_CNT;
                end
                if (div_stat.done) begin
                    n_mag   = quo;
                    n_s     = '0;
                    n_state = ST_U_WALK;
                end
            end
            ST_U_WALK: begin
                if (r_s == r_cnt) begin
                    n_state = ST_FIN_RD;
                end else begin
                    lst_re    = 1'b1;
                    lst_raddr = r_s[SW-1:0];
                    n_state   = ST_U_ENT;
                end
            end
            ST_U_ENT: begin
                n_e       = lst_q;
                ent_re    = 1'b1;
                ent_raddr = lst_q;
                n_state   = ST_U_M1;
            end
            ST_U_M1: begin
                n_ent   = ent_q;
                n_pp    = 40'(r_mag[23:0]) * 40'(q_t);
                n_state = ST_U_M2;
            end
            ST_U_M2: begin
                n_ph    = 39'(r_mag[MAG_W-1:24]) * 39'(e_t);
                n_state = ST_U_WR;
            end
            ST_U_WR: begin
                ent_we    = 1'b1;
                ent_waddr = r_e;
                ent_wdata = {wsat, e_t, e_p};
                n_s       = r_s + 1'b1;
                n_state   = ST_U_WALK;
            end
            ST_FIN_RD: begin
                ent_re    = 1'b1;
                ent_raddr = idx;
                n_state   = ST_FIN_Q;
            end
            ST_FIN_Q: begin
                if (!r_ov || o_res.ready) begin
                    n_ov    = 1'b1;
                    n_wo    = q_w;
                    n_to    = q_t;
                    n_co    = r_cnt;
                    n_mo    = r_min;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_ret   <= ST_FIN_RD;
            r_cnt   <= '0;
            r_min   <= MIN_RESET;
            r_lr    <= LR_RESET;
            r_tc    <= TC_RESET;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_s     <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_min   <= n_min;
            r_lr    <= n_lr;
            r_tc    <= n_tc;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_s     <= n_s;
        end
        r_cull  <= n_cull;  r_op   <= n_op;    r_red  <= n_red;   r_rate <= n_rate;
        r_delta <= n_delta; r_wv   <= n_wv;    r_slot <= n_slot;  r_e    <= n_e;
        r_ent   <= n_ent;   r_prod <= n_prod;  r_q    <= n_q;     r_p    <= n_p;
        r_neg   <= n_neg;   r_mag  <= n_mag;   r_pp   <= n_pp;    r_ph   <= n_ph;
        r_wo    <= n_wo;    r_to   <= n_to;    r_co   <= n_co;    r_mo   <= n_mo;
    end
endmodule
